>>> design/fip_pkg.sv
// ----------------------------------------------------------------------------
// Float integer power package
// Shared constants, the sequencer-to-unit control struct and the status struct.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } fop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fu_ctl_t;

  typedef struct packed {
    logic done;
    logic busy;
  } fu_sts_t;

endpackage

>>> design/fip_funit.sv
// ----------------------------------------------------------------------------
// Float integer power arithmetic unit
// Shared binary32 multiplier and iterative divider, round to nearest even.
// ----------------------------------------------------------------------------
module fip_funit (
  input  logic            clk,
  input  logic            rst_n,
  input  fip_pkg::fu_ctl_t ctl,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output fip_pkg::fu_sts_t sts,
  output logic [31:0]     y
);
  import fip_pkg::*;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_PREP = 5'b00010,
    U_MUL  = 5'b00100,
    U_DIV  = 5'b01000,
    U_RND  = 5'b10000
  } ust_t;

  ust_t        st_r, st_nxt;
  fop_t        op_r;
  logic        sgn_r;
  logic        spec_r;
  logic [31:0] spec_val_r;
  logic signed [10:0] exp_r;     // biased result exponent before normalising
  logic [23:0] ma_r, mb_r;
  logic [47:0] prod_r;           // significand product or divide quotient
  logic [25:0] rem_r;
  logic [5:0]  cnt_r;
  logic [31:0] y_r;
  logic        done_r;

  // Unpacked operands.
  logic        sa, sb, za, zb, ia, ib, na, nb;
  logic [7:0]  ea, eb;
  logic [23:0] fa, fb;
  logic [4:0]  lza, lzb;
  logic signed [10:0] xa, xb;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) if (v[i]) n = 5'(23 - i);
    return n;
  endfunction

  always_comb begin
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = {(ea != 8'd0), a[22:0]};
    fb = {(eb != 8'd0), b[22:0]};
    za = (ea == 8'd0) && (a[22:0] == 23'd0);
    zb = (eb == 8'd0) && (b[22:0] == 23'd0);
    ia = (ea == 8'hFF) && (a[22:0] == 23'd0);
    ib = (eb == 8'hFF) && (b[22:0] == 23'd0);
    na = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nb = (eb == 8'hFF) && (b[22:0] != 23'd0);
    lza = lzc24(fa);
    lzb = lzc24(fb);
    xa = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea}) - $signed({6'd0, lza});
    xb = $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - $signed({6'd0, lzb});
  end

  // Normalise and round stage.
  logic [47:0] nm;
  logic signed [10:0] ne;
  logic [24:0] mant;   // 24 kept bits plus carry
  logic        gbit, sticky;
  logic [47:0] sh;
  logic [6:0]  rsh;
  logic [31:0] rnd_y;

  always_comb begin
    // prod_r holds a value with its leading one at bit 46 or 47, exponent exp_r
    // referring to bit 46.
    if (prod_r[47]) begin
      nm = prod_r;
      ne = exp_r + 11'sd1;
    end else begin
      nm = prod_r << 1;
      ne = exp_r;
    end
    // Now the leading one is at bit 47; subnormal results shift right.
    rsh = 7'd0;
    if (ne < 11'sd1) rsh = (11'sd1 - ne > 11'sd40) ? 7'd40 : 7'(11'sd1 - ne);
    sh = nm >> rsh;
    sticky = ((nm & ((48'd1 << rsh) - 48'd1)) != 48'd0) || (|sh[22:0]) || (rem_r != 26'd0);
    gbit = sh[23];
    mant = {1'b0, sh[47:24]};
    if (gbit && (sticky || mant[0])) mant = mant + 25'd1;
    if (rsh != 7'd0) begin
      // subnormal: exponent field is 1 if rounding reached the hidden bit
      rnd_y = {sgn_r, (mant[23] ? 8'd1 : 8'd0), mant[22:0]};
    end else if (mant[24]) begin
      rnd_y = (ne + 11'sd1 >= 11'sd255) ? {sgn_r, 8'hFF, 23'd0}
                                        : {sgn_r, 8'(ne + 11'sd1), 23'd0};
    end else begin
      rnd_y = (ne >= 11'sd255) ? {sgn_r, 8'hFF, 23'd0} : {sgn_r, 8'(ne), mant[22:0]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      U_IDLE: if (ctl.start) st_nxt = U_PREP;
      U_PREP: st_nxt = spec_r ? U_IDLE : ((op_r == OP_MUL) ? U_MUL : U_DIV);
      U_MUL:  st_nxt = U_RND;
      U_DIV:  if (cnt_r == 6'd0) st_nxt = U_RND;
      U_RND:  st_nxt = U_IDLE;
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= ((st_r == U_PREP) && spec_r) || (st_r == U_RND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      U_IDLE: if (ctl.start) begin
        op_r  <= ctl.op;
        sgn_r <= sa ^ sb;
        ma_r  <= fa << lza;
        mb_r  <= fb << lzb;
        rem_r <= 26'd0;
        if (ctl.op == OP_MUL) begin
          exp_r <= xa + xb - 11'sd127;
          spec_r <= na || nb || ia || ib || za || zb;
          if (na || nb || (ia && zb) || (za && ib)) spec_val_r <= QNAN_BITS;
          else if (ia || ib) spec_val_r <= {sa ^ sb, 8'hFF, 23'd0};
          else spec_val_r <= {sa ^ sb, 31'd0};
        end else begin
          exp_r <= xa - xb + 11'sd127 - 11'sd1;
          spec_r <= na || nb || ia || ib || za || zb;
          if (na || nb || (ia && ib) || (za && zb)) spec_val_r <= QNAN_BITS;
          else if (ia || zb) spec_val_r <= {sa ^ sb, 8'hFF, 23'd0};
          else spec_val_r <= {sa ^ sb, 31'd0};
        end
      end
      U_PREP: begin
        if (spec_r) y_r <= spec_val_r;
        prod_r <= 48'd0;
        rem_r  <= {2'b00, ma_r};
        cnt_r  <= 6'd47;
      end
      U_MUL: begin
        prod_r <= ma_r * mb_r;
        rem_r  <= 26'd0;
      end
      U_DIV: begin
        // Restoring division, one quotient bit per cycle, 48 bits: quotient
        // of ma/mb scaled by 2^47 so the leading one lands at bit 46 or 47.
        if (rem_r >= {2'b00, mb_r}) begin
          prod_r <= {prod_r[46:0], 1'b1};
          rem_r  <= (rem_r - {2'b00, mb_r}) << 1;
        end else begin
          prod_r <= {prod_r[46:0], 1'b0};
          rem_r  <= rem_r << 1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
      U_RND: y_r <= rnd_y;
      default: ;
    endcase
  end

  assign sts.done = done_r;
  assign sts.busy = (st_r != U_IDLE);
  assign y = y_r;

endmodule

>>> design/fip_seq.sv
// ----------------------------------------------------------------------------
// Float integer power sequencer
// Walks the exponent magnitude bits, issuing squares and multiplies, then a divide for a negative exponent.
// ----------------------------------------------------------------------------
module fip_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_base_bits,
  input  logic signed [31:0] in_exponent,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_result_bits,
  output fip_pkg::fu_ctl_t ctl,
  output logic [31:0]      opa,
  output logic [31:0]      opb,
  input  fip_pkg::fu_sts_t sts,
  input  logic [31:0]      fy
);
  import fip_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_STEP = 6'b000010,
    S_SQW  = 6'b000100,
    S_MULW = 6'b001000,
    S_DIVW = 6'b010000,
    S_OUT  = 6'b100000
  } sst_t;

  sst_t        st_r, st_nxt;
  logic [31:0] x_r, acc_r, mag_r, res_r;
  logic        neg_r;
  logic [31:0] mag_in;

  assign mag_in = in_exponent[31] ? (32'd0 - in_exponent) : in_exponent;
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_result_bits = res_r;

  always_comb begin
    st_nxt = st_r;
    ctl.start = 1'b0;
    ctl.op = OP_MUL;
    opa = x_r;
    opb = x_r;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_STEP;
      S_STEP: begin
        if (mag_r != 32'd0) begin
          ctl.start = 1'b1;
          st_nxt = S_SQW;
        end else if (neg_r) begin
          ctl.start = 1'b1;
          ctl.op = OP_DIV;
          opa = ONE_BITS;
          opb = acc_r;
          st_nxt = S_DIVW;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_SQW: if (sts.done) begin
        if (mag_r[0]) begin
          ctl.start = 1'b1;
          opa = acc_r;
          opb = fy;
          st_nxt = S_MULW;
        end else st_nxt = S_STEP;
      end
      S_MULW: if (sts.done) st_nxt = S_STEP;
      S_DIVW: if (sts.done) st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        x_r   <= in_base_bits;
        acc_r <= mag_in[0] ? in_base_bits : ONE_BITS;
        mag_r <= mag_in >> 1;
        neg_r <= in_exponent[31];
        res_r <= mag_in[0] ? in_base_bits : ONE_BITS;
      end
      S_STEP: if (mag_r == 32'd0 && !neg_r) begin
        res_r <= (acc_r[30:23] == 8'hFF && acc_r[22:0] != 23'd0) ? QNAN_BITS : acc_r;
      end
      S_SQW: if (sts.done) begin
        x_r <= fy;
        if (!mag_r[0]) mag_r <= mag_r >> 1;
      end
      S_MULW: if (sts.done) begin
        acc_r <= fy;
        mag_r <= mag_r >> 1;
      end
      S_DIVW: if (sts.done) res_r <= fy;
      default: ;
    endcase
  end

endmodule

>>> design/float_integer_power.sv
// ----------------------------------------------------------------------------
// Float integer power
// Raises a binary32 base to a signed 32-bit integer power.
// ----------------------------------------------------------------------------
// One item at a time: square-and-multiply over the exponent magnitude on one
// shared float unit, then a 48-step divide for a negative exponent.
// The input is stalled from acceptance until the result transfer completes.
module float_integer_power (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_base_bits,
  input  logic signed [31:0] in_exponent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_result_bits
);
  import fip_pkg::*;

  fu_ctl_t     ctl;
  fu_sts_t     sts;
  logic [31:0] opa, opb, fy;

  fip_seq u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_base_bits, .in_exponent,
    .out_valid, .out_stall, .out_result_bits,
    .ctl, .opa, .opb, .sts, .fy
  );

  fip_funit u_funit (
    .clk, .rst_n, .ctl, .a(opa), .b(opb), .sts, .y(fy)
  );

  // Results never leave as a non-canonical NaN.
  a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result_bits[30:23] == 8'hFF && out_result_bits[22:0] != 23'd0
                    && out_result_bits != QNAN_BITS))
    else $error("non-canonical NaN on output");

  // The unit is only started while idle.
  a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !sts.busy)
    else $error("float unit started while busy");

  // The input is held off while a result is pending.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

endmodule

>>> verif/float_integer_power_test.sv
// ----------------------------------------------------------------------------
// Float integer power testbench
// Drives binary32 bases and signed exponents through the valid/stall channel.
// Each output transfer is checked against a bit-exact square-and-multiply
// predictor that does its own binary32 rounding. Idle and stall rates vary
// between phases, and one phase holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module float_integer_power_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fip_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_base_bits = '0;
  logic signed [31:0] in_exponent = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_result_bits;

  logic [31:0] pending_powers[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;
  int          holds_seen = 0;
  int          hold_left = 0;

  float_integer_power dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Round and pack: the value is sig / 2^63 * 2^e, with sig normalised.
  function automatic logic [31:0] round_pack(logic sgn, int e, logic [63:0] sig);
    int          be;
    int          sh;
    logic [23:0] m24;
    logic        guard;
    logic        sticky;
    logic [31:0] mag_bits;
    be = e + 127;
    if (be >= 255) return {sgn, 31'h7F80_0000};
    if (be < 1) begin
      sh = 1 - be;
      if (sh >= 64) sig = {63'd0, |sig};
      else sig = (sig >> sh) | {63'd0, |(sig & ((64'd1 << sh) - 64'd1))};
      be = 1;
    end
    m24 = sig[63:40];
    guard = sig[39];
    sticky = |sig[38:0];
    mag_bits = (32'(be - 1) << 23) + {8'd0, m24};
    if (guard && (sticky || m24[0])) mag_bits = mag_bits + 32'd1;
    if (mag_bits >= 32'h7F80_0000) mag_bits = 32'h7F80_0000;
    return {sgn, mag_bits[30:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 0);
  endfunction

  // Significand with hidden bit, and exponent with subnormals read as 1.
  function automatic logic [23:0] sig_of(logic [31:0] f);
    return (f[30:23] != 0) ? {1'b1, f[22:0]} : {1'b0, f[22:0]};
  endfunction

  function automatic int exp_of(logic [31:0] f);
    return (f[30:23] != 0) ? int'(f[30:23]) : 1;
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic [63:0] sig;
    int          e;
    sgn = a[31] ^ b[31];
    a_inf = a[30:0] == 31'h7F80_0000;
    b_inf = b[30:0] == 31'h7F80_0000;
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    if (is_nan(a) || is_nan(b)) return QNAN_BITS;
    if ((a_inf && b_zero) || (b_inf && a_zero)) return QNAN_BITS;
    if (a_inf || b_inf) return {sgn, 31'h7F80_0000};
    if (a_zero || b_zero) return {sgn, 31'd0};
    sig = {40'd0, sig_of(a)} * {40'd0, sig_of(b)};
    e = exp_of(a) + exp_of(b) - 254 - 46 + 63;
    while (!sig[63]) begin
      sig = sig << 1;
      e--;
    end
    return round_pack(sgn, e, sig);
  endfunction

  function automatic logic [31:0] frecip(logic [31:0] b);
    logic [63:0] q;
    logic [63:0] sig;
    int          e;
    if (is_nan(b)) return QNAN_BITS;
    if (b[30:0] == 31'h7F80_0000) return {b[31], 31'd0};
    if (b[30:0] == 0) return {b[31], 31'h7F80_0000};
    q = (64'd1 << 62) / {40'd0, sig_of(b)};
    sig = {q[63:1], q[0] | (((64'd1 << 62) % {40'd0, sig_of(b)}) != 0)};
    e = 88 - exp_of(b) + 63;
    while (!sig[63]) begin
      sig = sig << 1;
      e--;
    end
    return round_pack(b[31], e, sig);
  endfunction

  function automatic logic [31:0] predict_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] mag;
    logic [31:0] x;
    logic [31:0] acc;
    logic [31:0] res;
    mag = ex[31] ? -ex : ex;
    x = base;
    acc = mag[0] ? x : ONE_BITS;
    mag = mag >> 1;
    while (mag != 0) begin
      x = fmul(x, x);
      if (mag[0]) acc = fmul(acc, x);
      mag = mag >> 1;
    end
    res = ex[31] ? frecip(acc) : acc;
    return is_nan(res) ? QNAN_BITS : res;
  endfunction

  task automatic send_power(logic [31:0] base, logic [31:0] ex);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_bits <= base;
    in_exponent <= ex;
    do @(posedge clk); while (in_stall);
    pending_powers.push_back(predict_power(base, ex));
  endtask

  // Output stall, including the long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("result_bits: unexpected transfer, actual %h", out_result_bits);
        fail_count++;
      end else begin
        if (out_result_bits !== pending_powers[0]) begin
          $error("result_bits: expected %h actual %h", pending_powers[0], out_result_bits);
          fail_count++;
        end
        void'(pending_powers.pop_front());
      end
    end
  end

  function automatic logic [31:0] rand_base();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
      4: return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(0, 1) * 255), 23'($urandom_range(0, 3))};
    endcase
  endfunction

  function automatic logic [31:0] rand_exponent();
    logic [31:0] mag;
    case ($urandom_range(4))
      0: return $urandom;
      1: mag = $urandom_range(0, 300);
      default: mag = $urandom_range(0, 40);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic test_directed();
    logic [31:0] bases[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                               32'hFF80_0000, 32'hFFC1_2345, 32'h3F80_0000,
                               32'hBF80_0000, 32'h4000_0000, 32'h0000_0001,
                               32'h7F7F_FFFF, 32'h3F00_0000, 32'h807F_FFFF};
    logic [31:0] exps[9] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd127,
                             -32'd149};
    foreach (bases[i]) send_power(bases[i], exps[i % 9]);
    foreach (exps[i]) send_power(32'hC000_0000, exps[i]);
    send_power(32'h3F80_0001, 32'h8000_0000);
    send_power(32'h7FC0_0000, 32'd0);
    send_power(32'h0080_0000, 32'hFFFF_FFFF);
    send_power(32'h3FB5_04F3, 32'd255);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_power(rand_base(), rand_exponent());
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (20) send_power(rand_base(), rand_exponent());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(650, 31, 52);
    test_random(650, 52, 31);
    test_output_hold();
    test_random(600, 0, 0);
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
